FILE: rtl/circulant_route_record_macros.svh
// assertion macros for the circulant route record block
// each use expects clk and rst in scope
`ifndef CIRCULANT_ROUTE_RECORD_MACROS_SVH
`define CIRCULANT_ROUTE_RECORD_MACROS_SVH

`ifndef SYNTHESIS

`define CRR_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

`define CRR_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`else

`define CRR_ASSERT_IMP(lbl, ant, con, msg)

`define CRR_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

FILE: rtl/crr_pkg.sv
`default_nettype none

package crr_pkg;

  localparam int NODE_W  = 12;
  localparam int DELTA_W = 7;
  localparam int HOP_W   = 7;
  localparam int EXP_W   = 3;
  localparam int COORD_W = 7;
  localparam int SUM_W   = 15;

  localparam logic [EXP_W-1:0] SIZE_RESET = 3'd3;
  localparam logic [EXP_W-1:0] SIZE_MIN   = 3'd1;
  localparam int               SIZE_MAX   = 6;

  typedef struct packed {
    logic load;
    logic step;
    logic report;
  } crr_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic last_pair;
  } crr_stat_t;

  // node index mask for n = 4^k
  function automatic logic [NODE_W-1:0] mask_of(input logic [EXP_W-1:0] k);
    logic [NODE_W:0] n;
    n = (NODE_W+1)'(1) << {k, 1'b0};
    return NODE_W'(n - (NODE_W+1)'(1));
  endfunction

  // search bound 3*sy/4 with sy = 2^k
  function automatic logic [COORD_W-1:0] hi_of(input logic [EXP_W-1:0] k);
    logic [8:0] sy;
    logic [8:0] sy3;
    sy  = 9'(1) << k;
    sy3 = sy + (sy << 1);
    return COORD_W'(sy3 >> 2);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crr_datapath.sv
`default_nettype none

module crr_datapath #(
  parameter int MAX_NODES = 4096
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [crr_pkg::EXP_W-1:0]        cfg_wr_data,
  input  wire  [crr_pkg::NODE_W-1:0]       source_node,
  input  wire  [crr_pkg::NODE_W-1:0]       dest_node,
  input  crr_pkg::crr_cmd_t                cmd,
  output crr_pkg::crr_stat_t               status,
  output logic signed [crr_pkg::DELTA_W-1:0] delta_x,
  output logic signed [crr_pkg::DELTA_W-1:0] delta_y,
  output logic                             delta_z,
  output logic [crr_pkg::HOP_W-1:0]        hop_count,
  output logic                             route_found,
  output logic                             done
);
  import crr_pkg::*;

  localparam int MAX_EXP = ($clog2(MAX_NODES + 1) - 1) / 2;
  localparam int KMAX_I  = (MAX_EXP < SIZE_MAX) ? MAX_EXP : SIZE_MAX;
  localparam logic [EXP_W-1:0] KMAX = EXP_W'(KMAX_I);

  logic [EXP_W-1:0]         size_log4;
  logic [EXP_W-1:0]         k_eff;
  logic [EXP_W-1:0]         k;
  logic [NODE_W-1:0]        m;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] bx;
  logic signed [COORD_W-1:0] by;
  logic [HOP_W-1:0]         best;
  logic                     found;

  logic [COORD_W-1:0]       hi;
  logic [COORD_W-1:0]       hi_load;
  logic [NODE_W-1:0]        mask;
  logic [6:0]               sy;
  logic [5:0]               sx;
  logic [NODE_W:0]          n;
  logic signed [13:0]       xprod;
  logic signed [SUM_W-1:0]  yterm;
  logic signed [SUM_W-1:0]  s;
  logic [COORD_W-1:0]       ax;
  logic [COORD_W-1:0]       ay;
  logic [HOP_W-1:0]         d;
  logic                     match;
  logic                     y_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log4 <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_log4 <= cfg_wr_data;
    end
  end

  always_comb begin
    if (size_log4 < SIZE_MIN) begin
      k_eff = SIZE_MIN;
    end else if (size_log4 > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = size_log4;
    end
  end

  assign hi_load = hi_of(k_eff);
  assign hi      = hi_of(k);
  assign mask    = mask_of(k);
  assign sy      = 7'(1) << k;
  assign sx      = 6'((sy >> 1) - 7'd1);
  assign n       = (NODE_W+1)'(1) << {k, 1'b0};

  // candidate position x*sx + y*sy + n
  assign xprod = 14'(x) * 14'($signed({1'b0, sx}));
  assign yterm = SUM_W'(y) <<< k;
  assign s     = SUM_W'(xprod) + yterm + $signed({2'b00, n});
  assign match = !s[SUM_W-1] && ((s[NODE_W-1:0] & mask) == m);

  assign ax = x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
  assign ay = y[COORD_W-1] ? COORD_W'(-y) : COORD_W'(y);
  assign d  = HOP_W'(ax + ay);

  assign y_last           = (y == $signed(hi - COORD_W'(1)));
  assign status.last_pair = y_last && (x == $signed(hi - COORD_W'(1)));
  assign status.m_zero    = (m == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k     <= k_eff;
      m     <= (dest_node - source_node) & mask_of(k_eff);
      x     <= $signed(-hi_load);
      y     <= $signed(-hi_load);
      bx    <= '0;
      by    <= '0;
      best  <= '1;
      found <= 1'b0;
    end else if (cmd.step) begin
      // later matches of equal distance win
      if (match && (d <= best)) begin
        bx    <= x;
        by    <= y;
        best  <= d;
        found <= 1'b1;
      end
      if (y_last) begin
        y <= $signed(-hi);
        x <= x + COORD_W'(1);
      end else begin
        y <= y + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      delta_x     <= bx[COORD_W-1] ? DELTA_W'(bx - COORD_W'(1)) : DELTA_W'(bx + COORD_W'(1));
      delta_y     <= by[COORD_W-1] ? DELTA_W'(by - COORD_W'(1)) : DELTA_W'(by + COORD_W'(1));
      hop_count   <= found ? best : '0;
      route_found <= found || status.m_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  assign delta_z = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/crr_ctrl.sv
`default_nettype none

`include "circulant_route_record_macros.svh"

module crr_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  crr_pkg::crr_stat_t status,
  output crr_pkg::crr_cmd_t  cmd,
  output logic               busy
);
  import crr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // equal nodes skip the search
        cmd.step = !status.m_zero;
        if (status.m_zero || status.last_pair) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  `CRR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `CRR_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `CRR_ASSERT_NEXT(a_last_report, cmd.step && status.last_pair, cmd.report, "no report after last pair")
  `CRR_ASSERT_NEXT(a_report_idle, cmd.report, !busy && !cmd.step, "still busy after report")

endmodule

`default_nettype wire

FILE: rtl/circulant_route_record.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | start, busy          | source_node, dest_node
// result   | done (one cycle)     | delta_x, delta_y, delta_z, hop_count, route_found
// config   | cfg_wr_en            | cfg_wr_data (size_log4)
//
// a request is taken when start is high and busy low; the search steps through
// one (x, y) pair a cycle, (2*hi)^2 pairs with hi = 3*sy/4 rounded down
// the result strobe follows the last search step through the report state and the done
// register; equal nodes go from the search state to the report state without a step
// a new request can be taken in the cycle that done is high
// rst (synchronous) sets size_log4 to 3; the receiver cannot stall results

module circulant_route_record #(
  parameter int MAX_NODES = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [crr_pkg::NODE_W-1:0]          source_node,
  input  wire  [crr_pkg::NODE_W-1:0]          dest_node,
  input  wire                                 cfg_wr_en,
  input  wire  [crr_pkg::EXP_W-1:0]           cfg_wr_data,
  output logic                                done,
  output logic signed [crr_pkg::DELTA_W-1:0]  delta_x,
  output logic signed [crr_pkg::DELTA_W-1:0]  delta_y,
  output logic                                delta_z,
  output logic [crr_pkg::HOP_W-1:0]           hop_count,
  output logic                                route_found
);
  import crr_pkg::*;

  crr_cmd_t  cmd;
  crr_stat_t status;

  crr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  crr_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .source_node (source_node),
    .dest_node   (dest_node),
    .cmd         (cmd),
    .status      (status),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .delta_z     (delta_z),
    .hop_count   (hop_count),
    .route_found (route_found),
    .done        (done)
  );

endmodule

`default_nettype wire
